### hw/rtl/btls_pkg.sv
// Shared constants, types and codes for the BMP texture loader and sampler.
// Used by every module under hw/rtl; depends on nothing else.
package btls_pkg;

  // Sizing of the texture store and the sampler arithmetic.
  localparam int unsigned STORE_BYTES     = 262144;
  localparam int unsigned MAX_DIM         = 4096;
  localparam int unsigned COORD_FRAC_BITS = 16;

  localparam int unsigned COORD_W = COORD_FRAC_BITS + 1;
  localparam int unsigned DIM_W   = $clog2(MAX_DIM + 1);
  localparam int unsigned LC_W    = $clog2(STORE_BYTES + 1);
  localparam int unsigned ADDR_W  = $clog2(STORE_BYTES);
  localparam int unsigned PX_W    = COORD_W + DIM_W;
  localparam int unsigned RB_W    = DIM_W + 2;
  localparam int unsigned BASE_W  = DIM_W + RB_W;
  localparam int unsigned SA_W    = BASE_W + 1;
  localparam int unsigned CMP_W   = (SA_W > LC_W) ? SA_W : LC_W;

  // File format constants.
  localparam logic [7:0]  SIG_B     = 8'h42;
  localparam logic [7:0]  SIG_M     = 8'h4d;
  localparam logic [5:0]  HDR_LEN   = 6'd54;
  localparam logic [15:0] DEPTH_RGB = 16'd24;

  // Header byte positions.
  localparam logic [5:0] POS_OFF_LO = 6'd10;
  localparam logic [5:0] POS_OFF_HI = 6'd13;
  localparam logic [5:0] POS_W_LO   = 6'd18;
  localparam logic [5:0] POS_W_HI   = 6'd21;
  localparam logic [5:0] POS_H_LO   = 6'd22;
  localparam logic [5:0] POS_H_HI   = 6'd25;
  localparam logic [5:0] POS_D_LO   = 6'd28;
  localparam logic [5:0] POS_D_HI   = 6'd29;
  localparam logic [5:0] POS_SZ_LO  = 6'd34;
  localparam logic [5:0] POS_SZ_HI  = 6'd37;

  // Texture status codes.
  localparam logic [2:0] TS_READY    = 3'd0;
  localparam logic [2:0] TS_LOADING  = 3'd1;
  localparam logic [2:0] TS_BADSIG   = 3'd2;
  localparam logic [2:0] TS_BADDEPTH = 3'd3;
  localparam logic [2:0] TS_TOOBIG   = 3'd4;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } mem_wr_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [LC_W-1:0]  bytes;
  } tex_t;

endpackage

### hw/rtl/btls_mem.sv
// Texel byte store: one write port and one registered read port.
// Depends on btls_pkg.
module btls_mem (
  input  logic                      clk_i,
  input  btls_pkg::mem_wr_t         wr_i,
  input  logic                      rd_en_i,
  input  logic [btls_pkg::ADDR_W-1:0] rd_addr_i,
  output logic [7:0]                rd_data_o
);
  import btls_pkg::*;

  logic [7:0] mem [STORE_BYTES];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### hw/rtl/btls_parse.sv
// Header parser and image loader: tracks the file position, the captured
// header fields and the texture status, and issues writes to the store.
// Depends on btls_pkg.
module btls_parse (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              start_i,
  input  logic [7:0]        byte_i,
  output btls_pkg::mem_wr_t wr_o,
  output btls_pkg::tex_t    tex_o,
  output logic [2:0]        status_next_o
);
  import btls_pkg::*;

  logic [5:0]      hc_q, hc_d;
  logic [31:0]     off_q, off_d;
  logic [31:0]     w_q, w_d;
  logic [31:0]     h_q, h_d;
  logic [15:0]     dep_q, dep_d;
  logic [31:0]     ib_q, ib_d;
  logic [31:0]     skip_q, skip_d;
  logic [LC_W-1:0] lc_q, lc_d;
  logic [2:0]      st_q, st_d;

  always_comb begin
    logic [1:0] lane;
    logic       active;
    hc_d   = hc_q;
    off_d  = off_q;
    w_d    = w_q;
    h_d    = h_q;
    dep_d  = dep_q;
    ib_d   = ib_q;
    skip_d = skip_q;
    lc_d   = lc_q;
    st_d   = st_q;
    wr_o.en   = 1'b0;
    wr_o.addr = lc_q[ADDR_W-1:0];
    wr_o.data = byte_i;
    lane   = 2'd0;
    active = 1'b0;
    if (en_i) begin
      if (start_i) begin
        hc_d   = '0;
        off_d  = '0;
        w_d    = '0;
        h_d    = '0;
        dep_d  = '0;
        ib_d   = '0;
        skip_d = '0;
        lc_d   = '0;
        st_d   = TS_LOADING;
      end
      // Stray bytes outside a load are dropped.
      active = start_i || (st_q == TS_LOADING && hc_q != 6'd0);
      if (active) begin
        if (hc_d < HDR_LEN) begin
          if ((hc_d == 6'd0 && byte_i != SIG_B) || (hc_d == 6'd1 && byte_i != SIG_M)) begin
            st_d = TS_BADSIG;
          end else begin
            // All 32-bit fields start at a position that is 2 mod 4.
            lane = hc_d[1:0] + 2'd2;
            if (hc_d >= POS_OFF_LO && hc_d <= POS_OFF_HI) off_d[{lane, 3'b000} +: 8] = byte_i;
            if (hc_d >= POS_W_LO && hc_d <= POS_W_HI) w_d[{lane, 3'b000} +: 8] = byte_i;
            if (hc_d >= POS_H_LO && hc_d <= POS_H_HI) h_d[{lane, 3'b000} +: 8] = byte_i;
            if (hc_d >= POS_D_LO && hc_d <= POS_D_HI) dep_d[{hc_d[0], 3'b000} +: 8] = byte_i;
            if (hc_d >= POS_SZ_LO && hc_d <= POS_SZ_HI) ib_d[{lane, 3'b000} +: 8] = byte_i;
            if (hc_d == HDR_LEN - 6'd1) begin
              skip_d = (off_d > 32'(HDR_LEN)) ? off_d - 32'(HDR_LEN) : 32'd0;
              if (dep_d != DEPTH_RGB) begin
                st_d = TS_BADDEPTH;
              end else if (w_d == 32'd0 || h_d == 32'd0 ||
                           w_d > 32'(MAX_DIM) || h_d > 32'(MAX_DIM) ||
                           ib_d > 32'(STORE_BYTES)) begin
                st_d = TS_TOOBIG;
              end else if (ib_d == 32'd0) begin
                st_d = TS_READY;
              end
            end
            hc_d = hc_d + 6'd1;
          end
        end else if (skip_d != 32'd0) begin
          skip_d = skip_d - 32'd1;
        end else if (32'(lc_d) < ib_d && 32'(lc_d) < 32'(STORE_BYTES)) begin
          wr_o.en   = 1'b1;
          wr_o.addr = lc_d[ADDR_W-1:0];
          lc_d      = lc_d + LC_W'(1);
          if (32'(lc_d) == ib_d) begin
            st_d = TS_READY;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hc_q   <= '0;
      off_q  <= '0;
      w_q    <= '0;
      h_q    <= '0;
      dep_q  <= '0;
      ib_q   <= '0;
      skip_q <= '0;
      lc_q   <= '0;
      st_q   <= TS_LOADING;
    end else begin
      hc_q   <= hc_d;
      off_q  <= off_d;
      w_q    <= w_d;
      h_q    <= h_d;
      dep_q  <= dep_d;
      ib_q   <= ib_d;
      skip_q <= skip_d;
      lc_q   <= lc_d;
      st_q   <= st_d;
    end
  end

  // Width, height and size only matter once the texture is ready, and then
  // they are known to fit the narrow forms.
  assign tex_o.status  = st_q;
  assign tex_o.width   = w_q[DIM_W-1:0];
  assign tex_o.height  = h_q[DIM_W-1:0];
  assign tex_o.bytes   = ib_q[LC_W-1:0];
  assign status_next_o = st_d;

endmodule

### hw/rtl/btls_addr.sv
// Three-stage texel address pipeline: scale and clamp coordinates, form the
// bottom-up row base, then add the column offset. Depends on btls_pkg.
module btls_addr (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [btls_pkg::COORD_W-1:0] u_i,
  input  logic [btls_pkg::COORD_W-1:0] v_i,
  input  btls_pkg::tex_t               tex_i,
  output logic                         done_o,
  output logic [btls_pkg::SA_W-1:0]    addr_o
);
  import btls_pkg::*;

  localparam logic [COORD_W-1:0] ONE = COORD_W'(1) << COORD_FRAC_BITS;

  logic [2:0]        vld_q;
  logic [DIM_W-1:0]  x_q, y_q;
  logic [RB_W-1:0]   rb_q;
  logic [BASE_W-1:0] base_q;
  logic [RB_W-1:0]   x3_q;
  logic [SA_W-1:0]   addr_q;

  logic [COORD_W-1:0] uc, vc;
  logic [DIM_W-1:0]   wm1, hm1, row;
  logic [PX_W-1:0]    px, py;
  logic [RB_W-1:0]    w3;

  always_comb begin
    uc  = (u_i > ONE) ? ONE : u_i;
    vc  = (v_i > ONE) ? ONE : v_i;
    wm1 = tex_i.width - DIM_W'(1);
    hm1 = tex_i.height - DIM_W'(1);
    px  = PX_W'(uc) * PX_W'(wm1);
    py  = PX_W'(vc) * PX_W'(hm1);
    w3  = RB_W'(tex_i.width) * RB_W'(3) + RB_W'(3);
    row = hm1 - y_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q  <= px[COORD_FRAC_BITS +: DIM_W];
      y_q  <= py[COORD_FRAC_BITS +: DIM_W];
      rb_q <= {w3[RB_W-1:2], 2'b00};
    end
    if (vld_q[0]) begin
      base_q <= BASE_W'(row) * BASE_W'(rb_q);
      x3_q   <= RB_W'(x_q) * RB_W'(3);
    end
    if (vld_q[1]) begin
      addr_q <= SA_W'(base_q) + SA_W'(x3_q);
    end
  end

  assign done_o = vld_q[2];
  assign addr_o = addr_q;

endmodule

### hw/rtl/bmp_texture_load_and_sample.sv
// BMP texture loader and nearest-texel sampler, top level.
// Input beats carry either a file byte or a sample request (selected by
// s_axis_tuser_i[0]); every input beat produces exactly one output beat.
// File bytes parse the 54-byte header (signature, data offset, width,
// height, depth, image size), skip any gap and fill the texel store. Their
// output beat carries black and the status after the byte; file bytes run at
// one beat per cycle while no sample is busy and the output is taken.
// A sample request on a ready texture scales the clamped coordinates, forms
// the bottom-up, 4-byte padded texel address in a three-stage pipeline, then
// reads blue, green and red in turn through the single store read port.
// No new item is taken until its result is in the output register. A sample
// on a texture that is not ready returns black and the status, registered in
// the cycle after acceptance.
// Results sit in an output register: while idle, a new item is accepted if
// it is empty or being taken, so a stalled receiver holds the block after
// at most one waiting beat. Reset leaves the texture empty (status loading);
// store contents are not cleared, and a texture only reads bytes it wrote.
// Depends on btls_pkg, btls_parse, btls_addr and btls_mem.
module bmp_texture_load_and_sample (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // file_byte[7:0], u_coord[24:8], v_coord[41:25], zeros above
  input  logic [47:0] s_axis_tdata_i,
  // cmd[0], file_start[1]
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // red[7:0], green[15:8], blue[23:16], status[26:24], zeros above
  output logic [31:0] m_axis_tdata_o
);
  import btls_pkg::*;

  localparam logic [1:0] FSM_IDLE = 2'd0;
  localparam logic [1:0] FSM_ADDR = 2'd1;
  localparam logic [1:0] FSM_READ = 2'd2;
  localparam logic [1:0] FSM_DONE = 2'd3;

  localparam logic [1:0] RD_LAST = 2'd3;

  logic [1:0] fsm_q, fsm_d;
  logic [1:0] cnt_q;
  logic       ok_q;
  logic [7:0] blue_q, green_q, red_q;
  logic       out_valid_q;
  logic [7:0] out_red_q, out_green_q, out_blue_q;
  logic [2:0] out_status_q;

  logic              accept, out_free, is_sample;
  logic              byte_en, load_black, load_pix, load_byte;
  mem_wr_t           mem_wr;
  tex_t              tex;
  logic [2:0]        status_next;
  logic              addr_start, addr_done;
  logic [SA_W-1:0]   samp_addr, rd_addr;
  logic              rd_en, rd_ok;
  logic [7:0]        rd_data, rd_byte;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (fsm_q == FSM_IDLE) && out_free;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign is_sample       = s_axis_tuser_i[0];
  assign byte_en         = accept && !is_sample;
  assign load_byte       = byte_en;
  assign load_black      = accept && is_sample && tex.status != TS_READY;
  assign addr_start      = accept && is_sample && tex.status == TS_READY;
  assign load_pix        = (fsm_q == FSM_DONE) && out_free;

  btls_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (byte_en),
    .start_i      (s_axis_tuser_i[1]),
    .byte_i       (s_axis_tdata_i[7:0]),
    .wr_o         (mem_wr),
    .tex_o        (tex),
    .status_next_o(status_next)
  );

  btls_addr u_addr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(addr_start),
    .u_i    (s_axis_tdata_i[8 +: COORD_W]),
    .v_i    (s_axis_tdata_i[8 + COORD_W +: COORD_W]),
    .tex_i  (tex),
    .done_o (addr_done),
    .addr_o (samp_addr)
  );

  // One store byte per cycle: blue, green, red in address order.
  assign rd_en   = (fsm_q == FSM_READ) && cnt_q != RD_LAST;
  assign rd_addr = samp_addr + SA_W'(cnt_q);
  assign rd_ok   = CMP_W'(rd_addr) < CMP_W'(tex.bytes);

  btls_mem u_mem (
    .clk_i    (clk_i),
    .wr_i     (mem_wr),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr[ADDR_W-1:0]),
    .rd_data_o(rd_data)
  );

  assign rd_byte = ok_q ? rd_data : 8'd0;

  always_comb begin
    fsm_d = fsm_q;
    case (fsm_q)
      FSM_IDLE: if (addr_start) fsm_d = FSM_ADDR;
      FSM_ADDR: if (addr_done) fsm_d = FSM_READ;
      FSM_READ: if (cnt_q == RD_LAST) fsm_d = FSM_DONE;
      FSM_DONE: if (out_free) fsm_d = FSM_IDLE;
      default:  fsm_d = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= FSM_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fsm_q <= fsm_d;
      if (fsm_q == FSM_READ) begin
        cnt_q <= cnt_q + 2'd1;
      end else begin
        cnt_q <= '0;
      end
      if (load_byte || load_black || load_pix) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      ok_q <= rd_ok;
    end
    if (fsm_q == FSM_READ) begin
      case (cnt_q)
        2'd1:    blue_q  <= rd_byte;
        2'd2:    green_q <= rd_byte;
        RD_LAST: red_q   <= rd_byte;
        default: ;
      endcase
    end
    if (load_byte) begin
      out_red_q    <= 8'd0;
      out_green_q  <= 8'd0;
      out_blue_q   <= 8'd0;
      out_status_q <= status_next;
    end else if (load_black) begin
      out_red_q    <= 8'd0;
      out_green_q  <= 8'd0;
      out_blue_q   <= 8'd0;
      out_status_q <= tex.status;
    end else if (load_pix) begin
      out_red_q    <= red_q;
      out_green_q  <= green_q;
      out_blue_q   <= blue_q;
      out_status_q <= tex.status;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, out_status_q, out_blue_q, out_green_q, out_red_q};

  // The store is never written while a sample is reading it.
  a_no_write_in_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fsm_q != FSM_IDLE) |-> !mem_wr.en)
    else $error("texel store written during a sample");

  // Only a ready texture is ever read.
  a_read_when_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fsm_q == FSM_READ) |-> (tex.status == TS_READY))
    else $error("store read while texture not ready");

  // The address pipeline only finishes while the sequencer waits for it.
  a_addr_done_in_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    addr_done |-> (fsm_q == FSM_ADDR))
    else $error("address result with no sample waiting");

  // A texel color is only delivered with ready status.
  a_black_unless_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[26:24] != TS_READY) |->
      (m_axis_tdata_o[23:0] == 24'd0))
    else $error("color returned without a ready texture");

endmodule
